// File: rtl/thbh_pkg.sv
package thbh_pkg;

	localparam int DEF_BATCH_WIDTH = 24;
	localparam int DEF_TIME_WIDTH  = 32;

	localparam int CFG_W      = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int TEMP_W     = 8;
	localparam int IDLE_W     = 7;
	localparam int SCALE_W    = 17;
	localparam int FRAC_BITS  = 16;
	localparam int ACT_W      = 2;
	localparam int DIV_CNT_W  = 5;

	localparam logic [TEMP_W-1:0] TARGET_MIN   = 8'd40;
	localparam logic [TEMP_W:0]   CAP_MARGIN   = 9'd3;
	localparam logic [TEMP_W:0]   GLITCH_DROP  = 9'd12;
	localparam logic [TEMP_W:0]   HOT_MARGIN   = 9'd2;
	localparam logic [IDLE_W-1:0] IDLE_PER_DEG = 7'd12;
	localparam logic [IDLE_W-1:0] IDLE_MAX     = 7'd80;
	localparam logic [TEMP_W-1:0] IDLE_SAT_DEG = 8'd6;
	localparam logic [CFG_W-1:0]  SETTLE_MIN   = 32'd5000;
	localparam int                STEP_DEFAULT = 1000;

	localparam logic [TEMP_W-1:0] TARGET_RST = 8'd80;
	localparam logic [TEMP_W-1:0] CAP_RST    = 8'd83;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_USE_MEM,
		REG_TARGET,
		REG_CAP,
		REG_GPU_CAP,
		REG_PLANNED,
		REG_STEP,
		REG_MIN,
		REG_SETTLE
	} reg_addr_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_HOLD  = 2'd0,
		ACT_RAISE = 2'd1,
		ACT_CUT   = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CFG,
		S_BATCH,
		S_FLOOR,
		S_CUT1,
		S_CUT2,
		S_APPLY,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic cfg;
		logic batch;
		logic floor_lim;
		logic cut1;
		logic cut2;
		logic apply;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_busy;
	} status_t;

endpackage

// File: rtl/thbh_ctrl.sv
module thbh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  thbh_pkg::status_t st,
	output thbh_pkg::cmd_t    cmd
);
	import thbh_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_CFG;
				end
			end
			S_CFG: begin
				cmd.cfg = 1'b1;
				state_d = S_BATCH;
			end
			S_BATCH: begin
				cmd.batch = 1'b1;
				state_d   = S_FLOOR;
			end
			S_FLOOR: begin
				cmd.floor_lim = 1'b1;
				state_d       = S_CUT1;
			end
			S_CUT1: begin
				cmd.cut1 = 1'b1;
				state_d  = S_CUT2;
			end
			S_CUT2: begin
				cmd.cut2 = 1'b1;
				state_d  = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/thbh_dp.sv
module thbh_dp #(
	parameter int BATCH_WIDTH = thbh_pkg::DEF_BATCH_WIDTH,
	parameter int TIME_WIDTH  = thbh_pkg::DEF_TIME_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [thbh_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [thbh_pkg::CFG_W-1:0]       cfg_data,
	input  logic [thbh_pkg::TEMP_W-1:0]      gpu_temp,
	input  logic [thbh_pkg::TEMP_W-1:0]      mem_temp,
	input  logic [TIME_WIDTH-1:0]            time_ms,
	input  thbh_pkg::cmd_t                   cmd,
	output thbh_pkg::status_t                st,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [thbh_pkg::ACT_W-1:0]       action,
	output logic                             sensor_sel,
	output logic [thbh_pkg::TEMP_W-1:0]      control_temp,
	output logic [BATCH_WIDTH-1:0]           batch_size,
	output logic [thbh_pkg::IDLE_W-1:0]      idle_ms,
	output logic [thbh_pkg::SCALE_W-1:0]     scale_q16
);
	import thbh_pkg::*;

	localparam int B  = BATCH_WIDTH;
	localparam int SW = (B > 10) ? B : 10;
	localparam int AW = SW + 2;
	localparam int CW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

	// configuration
	logic              use_mem_q;
	logic [TEMP_W-1:0] target_q, cap_q, gcap_q;
	logic [B-1:0]      planned_q, min_q;
	logic [SW-1:0]     step_q;
	logic [CFG_W-1:0]  settle_q;

	// sample
	logic [TEMP_W-1:0]     gpu_q, mem_q;
	logic [TIME_WIDTH-1:0] now_q;

	// controller state
	logic                  started_q;
	logic [B-1:0]          cur_q, floor_q, good_q;
	logic [TEMP_W-1:0]     prev_q;
	logic [TIME_WIDTH-1:0] last_q;

	// pipeline
	logic [CFG_W-1:0]      settle_s1;
	logic [SW-1:0]         step_s1;
	logic [B-1:0]          plan_s1, mn_s1;
	logic [TEMP_W-1:0]     tgt_s1, ctl_s1;
	logic [TEMP_W:0]       cap_s1;
	logic                  sensor_s1;
	logic [TIME_WIDTH-1:0] since_s1;
	logic [B-1:0]          b_s2;
	logic                  may_s2, cool_s2, hot_s2;
	logic [IDLE_W-1:0]     idle_s2;
	logic [B-1:0]          fl_s3, ok_s3, up_s3;
	logic signed [AW-1:0]  d_s4;
	logic [B-1:0]          d_s5;

	// result and divider
	logic [ACT_W-1:0]     res_act_q;
	logic                 res_sensor_q;
	logic [TEMP_W-1:0]    res_ctl_q;
	logic [B-1:0]         res_batch_q;
	logic [IDLE_W-1:0]    res_idle_q;
	logic [B:0]           rem_q;
	logic [SCALE_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;

	// stage 1 logic
	logic [TEMP_W-1:0] tgt_c, ctl0_c, ctl1_c, ctl_c;
	logic [TEMP_W:0]   cap_c;
	logic [SW-1:0]     step_c, mn_a_c;
	logic [B-1:0]      plan_c, mn_c;
	logic              junction_c, ovr_c, glitch_c;

	always_comb begin
		tgt_c   = (target_q < TARGET_MIN) ? TARGET_MIN : target_q;
		cap_c   = (cap_q <= tgt_c) ? ({1'b0, tgt_c} + CAP_MARGIN) : {1'b0, cap_q};
		step_c  = (step_q == '0) ? SW'(STEP_DEFAULT) : step_q;
		plan_c  = (planned_q == '0) ? B'(1) : planned_q;
		mn_a_c  = (SW'(min_q) < step_c) ? step_c : SW'(min_q);
		mn_c    = (mn_a_c > SW'(plan_c)) ? plan_c : mn_a_c[B-1:0];
		junction_c = use_mem_q && (mem_q != '0);
		ctl0_c  = junction_c ? mem_q : gpu_q;
		ovr_c   = (gcap_q != '0) && (gpu_q >= gcap_q) && (gpu_q > ctl0_c);
		ctl1_c  = ovr_c ? gpu_q : ctl0_c;
		glitch_c = (prev_q >= tgt_c) && (ctl1_c != '0)
			&& ({1'b0, prev_q} >= ({1'b0, ctl1_c} + GLITCH_DROP));
		ctl_c   = glitch_c ? prev_q : ctl1_c;
	end

	// stage 2 logic
	logic [B-1:0]      b0_c, b1_c, b_c;
	logic              may_c, warm_c, rising_c, cool_c, hot_c;
	logic [TEMP_W-1:0] diff_c;
	logic [IDLE_W-1:0] idle_c;

	always_comb begin
		b0_c     = (cur_q == '0) ? plan_s1 : cur_q;
		b1_c     = (b0_c > plan_s1) ? plan_s1 : b0_c;
		b_c      = (b1_c < mn_s1) ? mn_s1 : b1_c;
		may_c    = CW'(since_s1) >= CW'(settle_s1);
		warm_c   = ctl_s1 >= tgt_s1;
		diff_c   = ctl_s1 - tgt_s1;
		if (!warm_c) begin
			idle_c = '0;
		end else if (diff_c >= IDLE_SAT_DEG) begin
			idle_c = IDLE_MAX;
		end else begin
			idle_c = (IDLE_W'(diff_c[2:0]) + IDLE_W'(1)) * IDLE_PER_DEG;
		end
		rising_c = (prev_q != '0) && (ctl_s1 > prev_q);
		cool_c   = (ctl_s1 <= tgt_s1) && !rising_c;
		hot_c    = ({1'b0, ctl_s1} >= cap_s1) || ({1'b0, ctl_s1} >= ({1'b0, tgt_s1} + HOT_MARGIN))
			|| (warm_c && rising_c);
	end

	// stage 3 logic
	logic [B-1:0]  fl0_c, fl_c, ok_c, up_c;
	logic [AW-1:0] sum_c;

	always_comb begin
		fl0_c = (floor_q == '0) ? b_s2 : floor_q;
		fl_c  = (fl0_c < mn_s1) ? mn_s1 : fl0_c;
		ok_c  = (good_q == '0) ? b_s2 : good_q;
		sum_c = AW'(b_s2) + AW'(step_s1);
		up_c  = (sum_c > AW'(plan_s1)) ? plan_s1 : sum_c[B-1:0];
	end

	// cut target logic
	logic signed [AW-1:0] fl_x, mn_x, b_x, step_x, ok_x, flst_x, d0_c, d1_c, d2_c, d3_c, d4_c;

	always_comb begin
		fl_x   = AW'(fl_s3);
		mn_x   = AW'(mn_s1);
		b_x    = AW'(b_s2);
		step_x = AW'(step_s1);
		ok_x   = AW'(ok_s3);
		flst_x = fl_x + step_x;
		d0_c   = (ok_x <= fl_x) ? flst_x : ok_x;
		d1_c   = (d0_c >= b_x) ? (b_x - step_x) : d0_c;
		d2_c   = (d_s4 <= fl_x) ? flst_x : d_s4;
		d3_c   = (d2_c < mn_x) ? mn_x : d2_c;
		d4_c   = (d3_c > b_x) ? b_x : d3_c;
	end

	// apply logic, the first sample only opens the window
	logic [B-1:0]          b_new_c, fl_new_c, good_new_c;
	logic [ACT_W-1:0]      act_c;
	logic                  touch_c, chg_c;

	always_comb begin
		b_new_c    = b_s2;
		fl_new_c   = fl_s3;
		good_new_c = ok_s3;
		act_c      = ACT_HOLD;
		touch_c    = 1'b0;
		chg_c      = d_s5 != b_s2;
		if (started_q && cool_s2) begin
			good_new_c = b_s2;
			if (may_s2 && (up_s3 != b_s2)) begin
				b_new_c = up_s3;
				act_c   = ACT_RAISE;
				touch_c = 1'b1;
			end
		end else if (started_q && hot_s2) begin
			if (chg_c && may_s2) begin
				b_new_c = d_s5;
				act_c   = ACT_CUT;
				touch_c = 1'b1;
			end
			if (chg_c && (b_new_c > fl_s3)) begin
				fl_new_c = b_new_c;
			end
		end
	end

	// divider step
	logic         ge_c;
	logic [B:0]   rsub_c;

	always_comb begin
		ge_c   = rem_q >= {1'b0, plan_s1};
		rsub_c = ge_c ? (rem_q - {1'b0, plan_s1}) : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_mem_q   <= 1'b0;
			target_q    <= TARGET_RST;
			cap_q       <= CAP_RST;
			gcap_q      <= '0;
			planned_q   <= B'(1);
			step_q      <= SW'(STEP_DEFAULT);
			min_q       <= '0;
			settle_q    <= SETTLE_MIN;
			started_q   <= 1'b0;
			cur_q       <= '0;
			floor_q     <= '0;
			good_q      <= '0;
			prev_q      <= '0;
			last_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_USE_MEM: use_mem_q <= cfg_data[0];
					REG_TARGET:  target_q  <= cfg_data[TEMP_W-1:0];
					REG_CAP:     cap_q     <= cfg_data[TEMP_W-1:0];
					REG_GPU_CAP: gcap_q    <= cfg_data[TEMP_W-1:0];
					REG_PLANNED: planned_q <= cfg_data[B-1:0];
					REG_STEP:    step_q    <= SW'(cfg_data[B-1:0]);
					REG_MIN:     min_q     <= cfg_data[B-1:0];
					REG_SETTLE:  settle_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.apply) begin
				cur_q  <= b_new_c;
				prev_q <= ctl_s1;
				cnt_q  <= '0;
				if (!started_q) begin
					started_q <= 1'b1;
					last_q    <= now_q;
					if (floor_q == '0) begin
						floor_q <= b_s2;
					end
					if (good_q == '0) begin
						good_q <= b_s2;
					end
				end else begin
					floor_q <= fl_new_c;
					good_q  <= good_new_c;
					if (touch_c) begin
						last_q <= now_q;
					end
				end
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gpu_q <= gpu_temp;
			mem_q <= mem_temp;
			now_q <= time_ms;
		end
		if (cmd.cfg) begin
			settle_s1 <= (settle_q < SETTLE_MIN) ? SETTLE_MIN : settle_q;
			step_s1   <= step_c;
			plan_s1   <= plan_c;
			mn_s1     <= mn_c;
			tgt_s1    <= tgt_c;
			cap_s1    <= cap_c;
			ctl_s1    <= ctl_c;
			sensor_s1 <= junction_c && !ovr_c;
			since_s1  <= now_q - last_q;
		end
		if (cmd.batch) begin
			b_s2    <= b_c;
			may_s2  <= may_c;
			idle_s2 <= idle_c;
			cool_s2 <= cool_c;
			hot_s2  <= hot_c;
		end
		if (cmd.floor_lim) begin
			fl_s3 <= fl_c;
			ok_s3 <= ok_c;
			up_s3 <= up_c;
		end
		if (cmd.cut1) begin
			d_s4 <= d1_c;
		end
		if (cmd.cut2) begin
			d_s5 <= d4_c[B-1:0];
		end
		if (cmd.apply) begin
			res_act_q    <= started_q ? act_c : ACT_HOLD;
			res_sensor_q <= sensor_s1;
			res_ctl_q    <= ctl_s1;
			res_batch_q  <= b_new_c;
			res_idle_q   <= started_q ? idle_s2 : '0;
			rem_q        <= {1'b0, b_new_c};
			quo_q        <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= {rsub_c[B-1:0], 1'b0};
			quo_q <= {quo_q[SCALE_W-2:0], ge_c};
		end
		if (cmd.load_out) begin
			action       <= res_act_q;
			sensor_sel   <= res_sensor_q;
			control_temp <= res_ctl_q;
			batch_size   <= res_batch_q;
			idle_ms      <= res_idle_q;
			scale_q16    <= quo_q;
		end
	end

	assign m_tvalid    = out_valid_q;
	assign st.div_last = cnt_q == DIV_CNT_W'(FRAC_BITS);
	assign st.out_busy = out_valid_q && !m_tready;

endmodule

// File: rtl/thermal_batch_hunt_controller_top.sv
// channel  | dir | beat contents (lsb first)
// s        | in  | tdata: gpu_temp[8], mem_temp[8], time_ms[TIME_WIDTH], zero pad
// m        | out | tdata: action[2], control_temp[8], batch_size[BATCH_WIDTH],
//          |     |        idle_ms[7], scale_q16[17], zero pad; tuser: sensor_sel
// cfg      | in  | cfg_we, cfg_addr (register index), cfg_data
//
// one sample runs through: accept, six decision steps, a 17-step restoring
// divider for scale_q16 (one quotient bit per cycle), and the result load
// a new sample is accepted as soon as the result sits in the output register
// a stalled output holds the finished sample back in the last step
// arst_n clears the output valid and the sample history and resets the registers to their defaults
module thermal_batch_hunt_controller_top #(
	parameter int BATCH_WIDTH = thbh_pkg::DEF_BATCH_WIDTH,
	parameter int TIME_WIDTH  = thbh_pkg::DEF_TIME_WIDTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((16 + TIME_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // gpu_temp, mem_temp, time_ms
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [((34 + BATCH_WIDTH + 7) / 8) * 8 - 1:0] m_tdata, // action, control_temp,
	                                                // batch_size, idle_ms, scale_q16
	output logic                                    m_tuser,  // sensor_sel
	input  logic                                    cfg_we,
	input  logic [thbh_pkg::CFG_ADDR_W-1:0]         cfg_addr,
	input  logic [thbh_pkg::CFG_W-1:0]              cfg_data
);
	import thbh_pkg::*;

	localparam int OUT_W    = ((34 + BATCH_WIDTH + 7) / 8) * 8;

	cmd_t    cmd;
	status_t st;

	logic [ACT_W-1:0]       action;
	logic [TEMP_W-1:0]      control_temp;
	logic [BATCH_WIDTH-1:0] batch_size;
	logic [IDLE_W-1:0]      idle_ms;
	logic [SCALE_W-1:0]     scale_q16;

	thbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	thbh_dp #(
		.BATCH_WIDTH (BATCH_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.gpu_temp     (s_tdata[TEMP_W-1:0]),
		.mem_temp     (s_tdata[2*TEMP_W-1:TEMP_W]),
		.time_ms      (s_tdata[2*TEMP_W+TIME_WIDTH-1:2*TEMP_W]),
		.cmd          (cmd),
		.st           (st),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.action       (action),
		.sensor_sel   (m_tuser),
		.control_temp (control_temp),
		.batch_size   (batch_size),
		.idle_ms      (idle_ms),
		.scale_q16    (scale_q16)
	);

	assign m_tdata = OUT_W'({scale_q16, idle_ms, batch_size, control_temp, action});

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import thbh_pkg::*;

	localparam int S_W         = ((16 + DEF_TIME_WIDTH + 7) / 8) * 8;
	localparam int M_W         = ((34 + DEF_BATCH_WIDTH + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		action_t      action;
		logic         sensor;
		logic [7:0]   temp;
		logic [23:0]  batch;
		logic [6:0]   idle;
		logic [16:0]  scale;
	} batch_result_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [S_W-1:0]  s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [M_W-1:0]  m_tdata;
	logic            m_tuser;
	logic            cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = REG_USE_MEM;
	logic [CFG_W-1:0] cfg_data = '0;

	// register copies, reset values
	logic         cfg_use_mem = 1'b0;
	logic [7:0]   cfg_target = TARGET_RST;
	logic [7:0]   cfg_cap = CAP_RST;
	logic [7:0]   cfg_gpu_cap = 8'd0;
	logic [23:0]  cfg_planned = 24'd1;
	logic [23:0]  cfg_step = 24'd1000;
	logic [23:0]  cfg_min = 24'd0;
	logic [31:0]  cfg_settle = SETTLE_MIN;

	// controller history
	logic         hist_started = 1'b0;
	logic [23:0]  hist_batch = '0;
	logic [23:0]  hist_floor = '0;
	logic [23:0]  hist_good = '0;
	logic [7:0]   hist_temp = '0;
	logic [31:0]  hist_change_ms = '0;
	logic [6:0]   hist_idle = '0;
	logic [15:0]  hist_cool = '0;

	logic [S_W-1:0] sample_q[$];
	batch_result_t  result_q[$];

	int error_count = 0;
	int sample_count = 0;
	int raise_count = 0;
	int cut_count = 0;
	int setting_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 23;
	int receiver_idle_pct = 23;
	logic [31:0] stamp = '0;

	thermal_batch_hunt_controller_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic batch_result_t predict_control(logic [7:0] gpu_t, logic [7:0] mem_t,
			logic [31:0] now);
		batch_result_t r;
		longint gpu, mem, step, plan, mn, b, ctl, tgt, cap, prev, fl, ok, want, dt, nx, d;
		logic [31:0] settle, since;
		logic [63:0] num, quot;
		logic junction, may, cool, hot;
		gpu = longint'(gpu_t);
		mem = longint'(mem_t);
		settle = (cfg_settle < SETTLE_MIN) ? SETTLE_MIN : cfg_settle;
		step = (cfg_step == 0) ? longint'(STEP_DEFAULT) : longint'(cfg_step);
		plan = (cfg_planned == 0) ? longint'(1) : longint'(cfg_planned);
		mn = longint'(cfg_min);
		if (mn < step) mn = step;
		if (mn > plan) mn = plan;
		b = longint'(hist_batch);
		if (b == 0) b = plan;
		if (b > plan) b = plan;
		if (b < mn) b = mn;

		r.action = ACT_HOLD;
		junction = cfg_use_mem && mem > 0;
		r.sensor = junction;
		ctl = junction ? mem : gpu;
		tgt = longint'(cfg_target);
		if (tgt < longint'(TARGET_MIN)) tgt = longint'(TARGET_MIN);
		cap = longint'(cfg_cap);
		if (cap <= tgt) cap = tgt + longint'(CAP_MARGIN);

		// gpu override
		if (cfg_gpu_cap != 0 && gpu >= longint'(cfg_gpu_cap) && gpu > ctl) begin
			ctl = gpu;
			r.sensor = 1'b0;
		end

		// glitch filter
		prev = longint'(hist_temp);
		if (prev >= tgt && ctl > 0 && prev - ctl >= longint'(GLITCH_DROP)) ctl = prev;

		if (!hist_started) begin
			hist_started = 1'b1;
			hist_change_ms = now;
			hist_temp = ctl[7:0];
			if (hist_floor == 0) hist_floor = b[23:0];
			if (hist_good == 0) hist_good = b[23:0];
			r.idle = '0;
		end else begin
			fl = longint'(hist_floor);
			ok = longint'(hist_good);
			if (fl == 0) fl = b;
			if (ok == 0) ok = b;
			if (fl < mn) fl = mn;

			since = now - hist_change_ms;
			may = since >= settle;

			want = 0;
			if (ctl >= tgt) begin
				want = longint'(IDLE_PER_DEG) * (ctl - tgt + 1);
				if (want > longint'(IDLE_MAX)) want = longint'(IDLE_MAX);
			end
			hist_idle = want[6:0];

			dt = (prev > 0) ? ctl - prev : 0;
			cool = ctl <= tgt && dt <= 0;
			hot = ctl >= cap || ctl >= tgt + longint'(HOT_MARGIN) || (ctl >= tgt && dt > 0);

			if (cool) begin
				ok = b;
				if (hist_cool != 16'hFFFF) hist_cool = hist_cool + 16'd1;
				nx = b + step;
				if (nx > plan) nx = plan;
				if (nx < mn) nx = mn;
				if (may && nx != b) begin
					b = nx;
					hist_change_ms = now;
					r.action = ACT_RAISE;
				end
			end else if (hot) begin
				hist_cool = '0;
				d = ok;
				if (d <= fl) d = fl + step;
				if (d >= b) d = b - step;
				if (d <= fl) d = fl + step;
				if (d < mn) d = mn;
				if (d > b) d = b;
				if (d != b) begin
					nx = d;
					if (nx > plan) nx = plan;
					if (nx < mn) nx = mn;
					if (may && nx != b) begin
						b = nx;
						hist_change_ms = now;
						r.action = ACT_CUT;
					end
					if (b > fl) fl = b;
				end
			end else begin
				hist_cool = '0;
			end

			hist_floor = fl[23:0];
			hist_good = ok[23:0];
			hist_temp = ctl[7:0];
			r.idle = hist_idle;
		end

		hist_batch = b[23:0];
		num = 64'(hist_batch) << FRAC_BITS;
		quot = num / 64'(plan);
		r.temp = ctl[7:0];
		r.batch = hist_batch;
		r.scale = quot[16:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= sample_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// result check, then prediction of the newly accepted sample
	always @(posedge clk) begin
		batch_result_t exp_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result beat, expected none actual %h", $time,
						m_tdata);
				end else begin
					exp_r = result_q.pop_front();
					check_field("action", 32'(exp_r.action), 32'(m_tdata[1:0]));
					check_field("sensor_sel", 32'(exp_r.sensor), 32'(m_tuser));
					check_field("control_temp", 32'(exp_r.temp), 32'(m_tdata[9:2]));
					check_field("batch_size", 32'(exp_r.batch), 32'(m_tdata[33:10]));
					check_field("idle_ms", 32'(exp_r.idle), 32'(m_tdata[40:34]));
					check_field("scale_q16", 32'(exp_r.scale), 32'(m_tdata[57:41]));
					check_field("pad", 32'd0, 32'(m_tdata[M_W-1:58]));
				end
			end
			if (s_tvalid && s_tready) begin
				exp_r = predict_control(s_tdata[7:0], s_tdata[15:8], s_tdata[47:16]);
				result_q.push_back(exp_r);
				sample_count++;
				if (exp_r.action == ACT_RAISE) raise_count++;
				if (exp_r.action == ACT_CUT) cut_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic write_reg(input reg_addr_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_USE_MEM: cfg_use_mem = val[0];
			REG_TARGET:  cfg_target = val[7:0];
			REG_CAP:     cfg_cap = val[7:0];
			REG_GPU_CAP: cfg_gpu_cap = val[7:0];
			REG_PLANNED: cfg_planned = val[23:0];
			REG_STEP:    cfg_step = val[23:0];
			REG_MIN:     cfg_min = val[23:0];
			REG_SETTLE:  cfg_settle = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(input logic use_mem, input logic [7:0] target,
			input logic [7:0] cap, input logic [7:0] gpu_cap, input logic [23:0] planned,
			input logic [23:0] step, input logic [23:0] min_b, input logic [31:0] settle);
		write_reg(REG_USE_MEM, 32'(use_mem));
		write_reg(REG_TARGET, 32'(target));
		write_reg(REG_CAP, 32'(cap));
		write_reg(REG_GPU_CAP, 32'(gpu_cap));
		write_reg(REG_PLANNED, 32'(planned));
		write_reg(REG_STEP, 32'(step));
		write_reg(REG_MIN, 32'(min_b));
		write_reg(REG_SETTLE, settle);
		setting_count++;
		@(negedge clk);
	endtask

	function automatic void push_sample(logic [7:0] gpu_t, logic [7:0] mem_t, logic [31:0] t);
		sample_q.push_back(S_W'({t, mem_t, gpu_t}));
	endfunction

	function automatic logic [7:0] pick_temp(int tgt_e);
		int v, j, r;
		r = $urandom_range(99);
		j = $urandom_range(20);
		if (r < 70) v = tgt_e - 6 + (j % 11);
		else if (r < 80) v = tgt_e - 12 - j;
		else if (r < 95) v = $urandom_range(255);
		else v = 0;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	function automatic void queue_random_samples(int count);
		int tgt_e, gc, v, r;
		logic [31:0] settle_e, span, gap;
		logic [7:0] gpu_t, mem_t;
		tgt_e = (cfg_target < TARGET_MIN) ? int'(TARGET_MIN) : int'(cfg_target);
		settle_e = (cfg_settle < SETTLE_MIN) ? SETTLE_MIN : cfg_settle;
		span = (settle_e > 32'd100000) ? 32'd200000 : settle_e * 2;
		gc = int'(cfg_gpu_cap);
		for (int i = 0; i < count; i++) begin
			mem_t = pick_temp(tgt_e);
			gpu_t = pick_temp(tgt_e);
			if ($urandom_range(99) < 20) begin
				v = gc - 1 + int'($urandom_range(3));
				if (v < 0) v = 0;
				if (v > 255) v = 255;
				gpu_t = v[7:0];
			end
			r = $urandom_range(99);
			if (r < 10) gap = $urandom();
			else if (r < 20) gap = settle_e - $urandom_range(1);
			else if (r < 30) gap = $urandom_range(200);
			else gap = $urandom_range(span);
			stamp = stamp + gap;
			push_sample(gpu_t, mem_t, stamp);
		end
	endfunction

	task automatic wait_results_done();
		do @(negedge clk);
		while (sample_q.size() != 0 || s_tvalid || result_q.size() != 0);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: first sample and field extremes
		push_sample(8'd0, 8'd0, 32'h0000_0000);
		push_sample(8'd255, 8'd255, 32'hFFFF_FFFF);
		push_sample(8'd80, 8'd0, 32'd5000);
		push_sample(8'd40, 8'd200, 32'hAAAA_AAAA);
		push_sample(8'd85, 8'd85, 32'h5555_5555);
		wait_results_done();

		// hot cut, settle gate, glitch, gpu override, cool raise, time wrap
		apply_settings(1'b1, 8'd70, 8'd75, 8'd90, 24'd20000, 24'd1000, 24'd3000, 32'd5000);
		push_sample(8'd60, 8'd65, 32'd10000);
		push_sample(8'd80, 8'd0, 32'd16000);
		push_sample(8'd72, 8'd72, 32'd16100);
		push_sample(8'd72, 8'd55, 32'd22200);
		push_sample(8'd95, 8'd70, 32'd28300);
		push_sample(8'd60, 8'd60, 32'd34400);
		push_sample(8'd60, 8'd60, 32'd34500);
		push_sample(8'd71, 8'd71, 32'd40600);
		push_sample(8'd70, 8'd70, 32'd46700);
		push_sample(8'd0, 8'd255, 32'd52800);
		push_sample(8'd255, 8'd0, 32'd58900);
		push_sample(8'd74, 8'd74, 32'hFFFF_F000);
		push_sample(8'd60, 8'd60, 32'h0000_0800);
		push_sample(8'd65, 8'd1, 32'h7FFF_FFFF);
		stamp = 32'h7FFF_FFFF;
		wait_results_done();

		apply_settings(1'b1, 8'd75, 8'd80, 8'd85, 24'd50000, 24'd2000, 24'd5000, 32'd5000);
		queue_random_samples(200);
		wait_results_done();

		apply_settings(1'b0, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0, 24'd0, 32'd0);
		queue_random_samples(100);
		wait_results_done();

		apply_settings(1'b1, 8'd255, 8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			32'hFFFF_FFFF);
		queue_random_samples(100);
		wait_results_done();

		apply_settings(1'b1, 8'd60, 8'd0, 8'd62, 24'hFFFFFF, 24'd0, 24'd0, 32'd20000);
		queue_random_samples(200);
		wait_results_done();

		// back to back, no stalls on either side
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		apply_settings(1'b0, 8'd85, 8'd90, 8'd200, 24'd30000, 24'd7000, 24'd2000, 32'd6000);
		queue_random_samples(150);
		wait_results_done();
		sender_idle_pct = 23;
		receiver_idle_pct = 23;

		apply_settings(1'b1, 8'd45, 8'd50, 8'd40, 24'd12345, 24'd100, 24'd0, 32'd5001);
		queue_random_samples(150);
		wait_results_done();

		apply_settings(1'($urandom_range(1)), 8'($urandom_range(30, 100)),
			8'($urandom_range(120)), 8'($urandom_range(255)), 24'($urandom_range(200000)),
			24'($urandom_range(20000)), 24'($urandom_range(50000)),
			32'($urandom_range(30000)));
		queue_random_samples(150);
		wait_results_done();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (result_q.size() != 0) begin
			error_count++;
			$display("%0t: results missing, expected %0d more actual 0", $time, result_q.size());
		end
		$display("run covered %0d samples under %0d register settings", sample_count,
			setting_count + 1);
		$display("batch raised %0d times and cut %0d times", raise_count, cut_count);
		if (error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
